// ----- rtl/modular_inverse_unit_defines.svh -----
// assertion macros shared by the modular inverse unit
`ifndef MODULAR_INVERSE_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_UNIT_DEFINES_SVH

// same-cycle implication
`define MI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mi_pkg.sv -----
package mi_pkg;

   localparam int FIELD_WIDTH = 32;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIV    = 6'b000010,
      S_END    = 6'b000100,
      S_CHECK  = 6'b001000,
      S_REDUCE = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP,
      OP_END_FIRST,
      OP_END_ROUND,
      OP_ROUND_INIT,
      OP_REDUCE,
      OP_OUTPUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic r_cur_zero;
   } status_type;

endpackage

// ----- rtl/mi_dp.sv -----
module mi_dp #(
   parameter int WIDTH = 32
) (
   input  logic                            clock,
   input  mi_pkg::cmd_type                 cmd,
   output mi_pkg::status_type              status,
   input  logic [mi_pkg::FIELD_WIDTH-1:0]  req_value,
   input  logic [mi_pkg::FIELD_WIDTH-1:0]  req_modulus,
   output logic [mi_pkg::FIELD_WIDTH-1:0]  rsp_inverse,
   output logic                            rsp_no_inverse
);
   import mi_pkg::*;

   logic [WIDTH-1:0] mod_ff, mod_in;
   logic             mod_zero_ff, mod_zero_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] r_prev_ff, r_prev_in;
   logic [WIDTH-1:0] r_cur_ff, r_cur_in;
   logic [WIDTH-1:0] t_prev_ff, t_prev_in;
   logic [WIDTH-1:0] t_cur_ff, t_cur_in;
   logic             neg_prev_ff, neg_prev_in;
   logic             neg_cur_ff, neg_cur_in;
   logic [FIELD_WIDTH-1:0] inv_ff, inv_in;
   logic             none_ff, none_in;

   logic [WIDTH-1:0] val_w;
   logic [WIDTH-1:0] mod_w;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   rem_sub;
   logic             ge;
   logic [WIDTH-1:0] rem_step;
   logic [WIDTH-1:0] acc_step;
   logic [WIDTH-1:0] t_red;
   logic [WIDTH-1:0] inv_w;
   logic             none_w;

   always_comb begin
      val_w = WIDTH'(req_value);
      mod_w = WIDTH'(req_modulus);

      // restoring division, one quotient bit per cycle
      rem_sh   = {rem_ff, num_ff[WIDTH-1]};
      rem_sub  = rem_sh - {1'b0, div_ff};
      ge       = rem_sh >= {1'b0, div_ff};
      rem_step = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      // quotient times t_cur, built msb first alongside the division
      acc_step = {acc_ff[WIDTH-2:0], 1'b0} + (ge ? t_cur_ff : '0);

      t_red  = (t_prev_ff >= mod_ff) ? t_prev_ff - mod_ff : t_prev_ff;
      inv_w  = (neg_prev_ff && (t_prev_ff != '0)) ? mod_ff - t_prev_ff : t_prev_ff;
      none_w = mod_zero_ff || (r_prev_ff != WIDTH'(1));
   end

   always_comb begin
      mod_in      = mod_ff;
      mod_zero_in = mod_zero_ff;
      div_in      = div_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      r_prev_in   = r_prev_ff;
      r_cur_in    = r_cur_ff;
      t_prev_in   = t_prev_ff;
      t_cur_in    = t_cur_ff;
      neg_prev_in = neg_prev_ff;
      neg_cur_in  = neg_cur_ff;
      inv_in      = inv_ff;
      none_in     = none_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            mod_in      = mod_w;
            mod_zero_in = (mod_w == '0);
            div_in      = mod_w;
            num_in      = val_w;
            rem_in      = '0;
            acc_in      = '0;
            r_prev_in   = mod_w;
            t_prev_in   = '0;
            t_cur_in    = WIDTH'(1);
            neg_prev_in = 1'b0;
            neg_cur_in  = 1'b0;
         end
         OP_STEP: begin
            num_in = {num_ff[WIDTH-2:0], 1'b0};
            rem_in = rem_step;
            acc_in = acc_step;
         end
         OP_END_FIRST: begin
            r_cur_in = rem_ff;
         end
         OP_END_ROUND: begin
            r_prev_in   = r_cur_ff;
            r_cur_in    = rem_ff;
            t_prev_in   = t_cur_ff;
            // signs alternate, so magnitudes add
            t_cur_in    = t_prev_ff + acc_ff;
            neg_prev_in = neg_cur_ff;
            neg_cur_in  = !neg_cur_ff;
         end
         OP_ROUND_INIT: begin
            num_in = r_prev_ff;
            div_in = r_cur_ff;
            rem_in = '0;
            acc_in = '0;
         end
         OP_REDUCE: begin
            t_prev_in = t_red;
         end
         OP_OUTPUT: begin
            inv_in  = none_w ? '0 : FIELD_WIDTH'(inv_w);
            none_in = none_w;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mod_ff      <= mod_in;
      mod_zero_ff <= mod_zero_in;
      div_ff      <= div_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      r_prev_ff   <= r_prev_in;
      r_cur_ff    <= r_cur_in;
      t_prev_ff   <= t_prev_in;
      t_cur_ff    <= t_cur_in;
      neg_prev_ff <= neg_prev_in;
      neg_cur_ff  <= neg_cur_in;
      inv_ff      <= inv_in;
      none_ff     <= none_in;
   end

   assign status.r_cur_zero = (r_cur_ff == '0);
   assign rsp_inverse       = inv_ff;
   assign rsp_no_inverse    = none_ff;

endmodule

// ----- rtl/mi_ctrl.sv -----
`include "modular_inverse_unit_defines.svh"

module mi_ctrl #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  mi_pkg::status_type status,
   output mi_pkg::cmd_type    cmd
);
   import mi_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             round_ff, round_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      round_in  = round_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               round_in = 1'b0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_STEP;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = S_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_END: begin
            cmd.op   = round_ff ? OP_END_ROUND : OP_END_FIRST;
            round_in = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.r_cur_zero) begin
               state_in = S_REDUCE;
            end else begin
               cmd.op   = OP_ROUND_INIT;
               state_in = S_DIV;
            end
         end
         S_REDUCE: begin
            cmd.op   = OP_REDUCE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.op   = OP_OUTPUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = (cmd.op == OP_OUTPUT) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         round_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MI_ASSERT_NXT(a_accept_starts_div, clock, reset, req_valid && !req_stall, state_ff == S_DIV, "accepted word did not start a division")
   `MI_ASSERT_NXT(a_output_sets_valid, clock, reset, cmd.op == OP_OUTPUT, rsp_valid_ff, "result written without valid")
   `MI_ASSERT_IMP(a_cnt_idle_zero, clock, reset, state_ff != S_DIV, cnt_ff == '0, "step counter left nonzero outside division")
   `MI_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.op == OP_OUTPUT, out_free, "pending result overwritten")

endmodule

// ----- rtl/modular_inverse_unit.sv -----
// each word runs bit-serial euclid divisions until the remainder is zero, then a
// reduce step; then the result is written and rsp_valid is raised with it
// each division steps in S_DIV, then S_END latches the remainder and S_CHECK tests it
// throughput: one word at a time, the next word taken only after the last result is
// written; a new word is taken while the last result waits
// reset: synchronous, active high; clears the controller and the result valid
module modular_inverse_unit #(
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mi_pkg::FIELD_WIDTH-1:0] req_value,
   input  logic [mi_pkg::FIELD_WIDTH-1:0] req_modulus,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mi_pkg::FIELD_WIDTH-1:0] rsp_inverse,
   output logic                           rsp_no_inverse
);
   import mi_pkg::*;

   cmd_type    cmd;
   status_type status;

   mi_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mi_dp #(
      .WIDTH(WIDTH)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .req_modulus    (req_modulus),
      .rsp_inverse    (rsp_inverse),
      .rsp_no_inverse (rsp_no_inverse)
   );

endmodule
